[rtl/core/mmle_pkg.sv]
// package for the multi-mode line encoder: widths, coding mode codes,
// the 4b5b code table and the queue entry and status types
// no dependencies
package mmle_pkg;

  localparam int BYTE_W      = 8;
  localparam int MODE_W      = 2;
  localparam int CODE_W      = 16;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_NRZ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_4B5B = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // index of the final coded bit for each mode
  localparam logic [CNT_W-1:0] NRZ_LAST  = 4'd7;
  localparam logic [CNT_W-1:0] MAN_LAST  = 4'd15;
  localparam logic [CNT_W-1:0] FBFB_LAST = 4'd9;

  // standard 4b5b codes, bit 4 goes out first
  localparam logic [4:0] CODE_4B5B [16] = '{
    5'h1E, 5'h09, 5'h14, 5'h15, 5'h0A, 5'h0B, 5'h0E, 5'h0F,
    5'h12, 5'h13, 5'h16, 5'h17, 5'h1A, 5'h1B, 5'h1C, 5'h1D
  };

  // one coded byte: bits left aligned, index of its last bit
  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [CNT_W-1:0]  last_idx;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

[rtl/core/mmle_if.sv]
// channel interfaces of the line encoder: byte input, coded bit output
// and coding mode write port; depends on mmle_pkg
interface mmle_in_if;
  logic                        valid;
  logic                        ready;
  logic [mmle_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mmle_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic last_bit;
  modport source (output valid, output line_level, output last_bit, input ready);
  modport sink (input valid, input line_level, input last_bit, output ready);
endinterface

interface mmle_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mmle_pkg::MODE_W-1:0] coding_mode;
  modport source (output valid, output coding_mode, input ready);
  modport sink (input valid, input coding_mode, output ready);
endinterface

[rtl/core/mmle_front.sv]
// front end: holds the coding mode, accepts bytes and codes each one
// into a left-aligned bit word for the queue; depends on mmle_pkg, mmle_if
module mmle_front (
  input  logic                    clk,
  input  logic                    rst_n,
  mmle_in_if.sink                 in_ch,
  mmle_cfg_if.sink                cfg_ch,
  input  mmle_pkg::queue_status_t q_stat,
  output logic                    push,
  output mmle_pkg::entry_t        push_entry
);
  import mmle_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [CODE_W-1:0] man_bits;
  logic              in_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      man_bits[2*k+1] = ~in_ch.data_byte[k];
      man_bits[2*k]   = in_ch.data_byte[k];
    end
  end

  always_comb begin
    push_entry = '0;
    case (mode_r)
      MODE_NRZ: begin
        push_entry.bits     = {in_ch.data_byte, {(CODE_W-BYTE_W){1'b0}}};
        push_entry.last_idx = NRZ_LAST;
      end
      MODE_MAN: begin
        push_entry.bits     = man_bits;
        push_entry.last_idx = MAN_LAST;
      end
      MODE_4B5B: begin
        push_entry.bits     = {CODE_4B5B[in_ch.data_byte[7:4]],
                               CODE_4B5B[in_ch.data_byte[3:0]], 6'b0};
        push_entry.last_idx = FBFB_LAST;
      end
      default: begin
        push_entry = '0;
      end
    endcase
  end

  // mode three words are taken and dropped
  assign push = in_fire && (mode_r != MODE_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NRZ;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      mode_r <= cfg_ch.coding_mode;
    end
  end

endmodule

[rtl/core/mmle_fifo.sv]
// short queue of coded bytes between front end and serializer
// depends on mmle_pkg
module mmle_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  mmle_pkg::entry_t        push_entry,
  input  logic                    pop,
  output mmle_pkg::entry_t        head,
  output mmle_pkg::queue_status_t q_stat
);
  import mmle_pkg::*;

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[rtl/core/mmle_back.sv]
// serializer: takes coded bytes from the queue and sends one bit per word
// through an output register, flagging the last; depends on mmle_pkg, mmle_if
module mmle_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mmle_pkg::entry_t        head,
  input  mmle_pkg::queue_status_t q_stat,
  output logic                    pop,
  mmle_out_if.source              out_ch
);
  import mmle_pkg::*;

  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              level_r, level_nxt;
  logic              last_r, last_nxt;
  logic              adv;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = level_r;
  assign out_ch.last_bit   = last_r;

  // output register free or emptying this cycle
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    busy_nxt      = busy_r;
    shift_nxt     = shift_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    level_nxt     = level_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (busy_r && adv) begin
      out_valid_nxt = 1'b1;
      level_nxt     = shift_r[CODE_W-1];
      last_nxt      = (left_r == '0);
      shift_nxt     = {shift_r[CODE_W-2:0], 1'b0};
      left_nxt      = left_r - CNT_W'(1);
      if (left_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
    // load the next byte as soon as the current one sends its last bit
    if ((!busy_r || (adv && left_r == '0)) && !q_stat.empty) begin
      pop       = 1'b1;
      shift_nxt = head.bits;
      left_nxt  = head.last_idx;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    left_r  <= left_nxt;
    level_r <= level_nxt;
    last_r  <= last_nxt;
  end

endmodule

[rtl/core/multi_mode_line_encoder_top.sv]
// top level of the multi-mode line encoder: front end, queue, serializer
// depends on mmle_pkg, mmle_if, mmle_front, mmle_fifo, mmle_back
//
//   channel  dir  payload            meaning
//   in_ch    in   data_byte[7:0]     byte to code, msb first
//   out_ch   out  line_level, last   one coded bit per word
//   cfg_ch   in   coding_mode[1:0]   0 nrz, 1 manchester, 2 4b5b
//
// a byte leaves as 8 (nrz), 16 (manchester) or 10 (4b5b) output words, one
// per cycle while out_ch.ready is high, from the serializer shift register;
// bytes of mode three are taken and give no words
// the two-entry queue takes new bytes while the serializer is busy;
// in_ch.ready drops once it is full
// out_ch.ready low freezes the serializer with its bit held in the output register
// reset sets the mode to nrz and empties queue and serializer
module multi_mode_line_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  mmle_in_if.sink     in_ch,
  mmle_cfg_if.sink    cfg_ch,
  mmle_out_if.source  out_ch
);
  import mmle_pkg::*;

  logic          push;
  logic          pop;
  entry_t        push_entry;
  entry_t        head;
  queue_status_t q_stat;

  mmle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  mmle_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mmle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
